// ===== rtl/core/spm_pkg.sv =====
`timescale 1ns / 1ps

package spm_pkg;

    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    // Broadcast from the control logic to every cell of the row.
    typedef struct packed {
        logic       load;
        logic       scan;
        logic       clear;
        logic [7:0] char_value;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/spm_item_if.sv =====
`timescale 1ns / 1ps

interface spm_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] char_value;
    logic       final_flag;

    modport source (output valid, output func, output char_value, output final_flag,
                    input ready);
    modport sink   (input valid, input func, input char_value, input final_flag,
                    output ready);
endinterface

// ===== rtl/core/spm_result_if.sv =====
`timescale 1ns / 1ps

interface spm_result_if;
    logic valid;
    logic ready;
    logic found;
    logic pattern_overflow;

    modport source (output valid, output found, output pattern_overflow, input ready);
    modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface

// ===== rtl/core/spm_cell.sv =====
`timescale 1ns / 1ps

module spm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spm_pkg::cell_ctrl_t ctrl,
    input  logic               wr_sel,
    input  logic               active,
    input  logic               is_last,
    input  logic               match_in,
    output logic               match_out,
    output logic               hit
);
    import spm_pkg::*;

    logic [7:0] byte_reg;
    logic       match_reg;
    logic       match_next;

    // A cell beyond the pattern length never matches, so its stale byte is harmless.
    assign match_next = match_in && active && (byte_reg == ctrl.char_value);
    assign hit        = ctrl.scan && match_next && is_last;
    assign match_out  = match_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && wr_sel)
        begin
            byte_reg <= ctrl.char_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.scan)
        begin
            match_reg <= match_next;
        end
    end
endmodule

// ===== rtl/core/substring_presence_matcher.sv =====
`timescale 1ns / 1ps

// Substring presence matcher (shift-and search).
// The item channel carries one byte per transaction. With func at the
// pattern code the byte is appended to the pattern; with func at the text
// code it is scanned against the pattern. final_flag on a pattern byte has no
// effect. final_flag on a text byte ends the query: one transaction appears
// on the result channel with found and pattern_overflow, and the pattern
// length, match bits and flags return to their reset values.
// Pattern bytes past MAX_PATTERN are dropped and the result reports overflow.
// Each pattern position is one cell of a row; every text byte is compared in
// all cells in the same cycle and the match bits shift one cell along.
// Throughput is one byte per cycle when no result is waiting. The result is
// registered and appears in the cycle after the final text byte is accepted.
// While a result waits for the receiver, no byte of any kind is accepted; a
// result taken in a cycle frees the register for a byte in that same cycle.
// Reset clears the pattern length, match bits and flags; it takes effect at once.
module substring_presence_matcher #(
    parameter int MAX_PATTERN = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    spm_item_if.sink       item,
    spm_result_if.source   result
);
    import spm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   found_reg;
    logic                   found_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic                   out_ovf_reg;
    logic                   accept;
    logic                   finish;
    logic                   hit_any;
    cell_ctrl_t             ctrl;
    logic [MAX_PATTERN-1:0] wr_sel;
    logic [MAX_PATTERN-1:0] active;
    logic [MAX_PATTERN-1:0] is_last;
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN:0]   chain;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign finish     = accept && (item.func == FUNC_TEXT) && item.final_flag;

    assign ctrl.load       = accept && (item.func == FUNC_PATTERN)
                             && (len_reg < LEN_W'(MAX_PATTERN));
    assign ctrl.scan       = accept && (item.func == FUNC_TEXT);
    assign ctrl.clear      = finish;
    assign ctrl.char_value = item.char_value;

    // The first cell always sees a match coming in: a match may start anywhere.
    assign chain[0] = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        assign wr_sel[k]  = (len_reg == LEN_W'(k));
        assign active[k]  = (LEN_W'(k) < len_reg);
        assign is_last[k] = (len_reg == LEN_W'(k + 1));

        spm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .wr_sel    (wr_sel[k]),
            .active    (active[k]),
            .is_last   (is_last[k]),
            .match_in  (chain[k]),
            .match_out (chain[k+1]),
            .hit       (hit[k])
        );
    end

    assign hit_any = |hit;

    always_comb
    begin
        len_next   = len_reg;
        found_next = found_reg;
        ovf_next   = ovf_reg;
        if (finish)
        begin
            len_next   = '0;
            found_next = 1'b0;
            ovf_next   = 1'b0;
        end
        else if (accept && (item.func == FUNC_PATTERN))
        begin
            if (ctrl.load)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else if (ctrl.scan && hit_any)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            found_reg <= found_next;
            ovf_reg   <= ovf_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_found_reg <= (found_reg || hit_any) && !ovf_reg && (len_reg != '0);
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.found            = out_found_reg;
    assign result.pattern_overflow = out_ovf_reg;
endmodule
